// ===== rtl/gf256_arithmetic_unit_assert.svh =====
// assertion macros for the gf256 arithmetic unit
// expects clk_i and rst_ni in the including module's scope
`ifndef GF256_ARITHMETIC_UNIT_ASSERT_SVH
`define GF256_ARITHMETIC_UNIT_ASSERT_SVH

// same-cycle implication
`define GF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gf256 check failed");

// next-cycle implication
`define GF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gf256 check failed");

`endif

// ===== rtl/gf256_pkg.sv =====
// shared types, opcodes and the field multiply for the gf256 arithmetic unit
// no dependencies
`default_nettype none

package gf256_pkg;

  localparam logic [1:0] OP_MUL = 2'd0;
  localparam logic [1:0] OP_DIV = 2'd1;
  localparam logic [1:0] OP_INV = 2'd2;
  localparam logic [1:0] OP_POW = 2'd3;

  localparam logic [7:0] GF_RED   = 8'h1b;
  localparam logic [7:0] INV_EXP  = 8'd254;
  localparam logic [8:0] GF_ORDER = 9'd255;

  typedef struct packed {
    logic load;
    logic step;
    logic fin;
  } gf_cmd_t;

  typedef struct packed {
    logic exp_zero;
    logic need_mul;
  } gf_sts_t;

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    acc = 8'h00;
    x   = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        acc = acc ^ x;
      end
      x = x[7] ? ({x[6:0], 1'b0} ^ GF_RED) : {x[6:0], 1'b0};
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gf256_ctrl.sv =====
// sequencer for the gf256 arithmetic unit
// depends on gf256_pkg for the command and status structs
`default_nettype none

module gf256_ctrl
  import gf256_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start,
  output logic         busy,
  output logic         done_o,
  output gf_cmd_t      cmd_o,
  input  wire gf_sts_t sts_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXP  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXP;
        end
      end
      ST_EXP: begin
        if (!sts_i.exp_zero) begin
          cmd_o.step = 1'b1;
        end else if (sts_i.need_mul) begin
          state_d = ST_MUL;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_MUL: begin
        cmd_o.fin = 1'b1;
        state_d   = ST_OUT;
      end
      ST_OUT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_OUT);

endmodule

`default_nettype wire

// ===== rtl/gf256_dp.sv =====
// datapath of the gf256 arithmetic unit: operand setup, exponent reduction,
// square-and-multiply registers; depends on gf256_pkg
`default_nettype none

module gf256_dp
  import gf256_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire gf_cmd_t     cmd_i,
  output gf_sts_t          sts_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [7:0]  operand_a_i,
  input  wire logic [7:0]  operand_b_i,
  input  wire logic [31:0] exponent_i,
  output logic [7:0]       result_o,
  output logic             zero_divisor_o
);

  logic [7:0] r_q, r_d;
  logic [7:0] s_q, s_d;
  logic [7:0] e_q, e_d;
  logic [7:0] a_q, a_d;
  logic       zd_q, zd_d;
  logic       nm_q, nm_d;

  logic [9:0] byte_sum;
  logic [8:0] fold;
  logic [8:0] fold_red;
  logic [7:0] exp_red;
  logic [7:0] mul_lhs;
  logic [7:0] prod;
  logic [7:0] sq;

  // 256 = 1 mod 255, so the byte sum keeps the residue; 2^32 = 1 corrects the sign
  assign byte_sum = {2'b00, exponent_i[7:0]} + {2'b00, exponent_i[15:8]}
                  + {2'b00, exponent_i[23:16]} + {2'b00, exponent_i[31:24]}
                  - {9'd0, exponent_i[31]};
  assign fold     = {7'd0, byte_sum[9:8]} + {1'b0, byte_sum[7:0]};
  assign fold_red = (fold >= GF_ORDER) ? (fold - GF_ORDER) : fold;
  assign exp_red  = fold_red[7:0];

  assign mul_lhs = cmd_i.fin ? a_q : s_q;
  assign prod    = gf_mul(r_q, mul_lhs);
  assign sq      = gf_mul(s_q, s_q);

  always_comb begin
    r_d  = r_q;
    s_d  = s_q;
    e_d  = e_q;
    a_d  = a_q;
    zd_d = zd_q;
    nm_d = nm_q;
    if (cmd_i.load) begin
      a_d  = operand_a_i;
      r_d  = 8'd1;
      s_d  = operand_a_i;
      e_d  = 8'd0;
      zd_d = 1'b0;
      nm_d = 1'b0;
      unique case (opcode_i)
        OP_MUL: begin
          r_d  = operand_b_i;
          nm_d = 1'b1;
        end
        OP_DIV: begin
          if (operand_b_i == 8'd0) begin
            r_d  = operand_a_i;
            zd_d = 1'b1;
          end else begin
            s_d  = operand_b_i;
            e_d  = INV_EXP;
            nm_d = 1'b1;
          end
        end
        OP_INV: begin
          if (operand_a_i == 8'd0) begin
            zd_d = 1'b1;
          end else begin
            e_d = INV_EXP;
          end
        end
        OP_POW: begin
          e_d = exp_red;
        end
        default: begin
          e_d = 8'd0;
        end
      endcase
    end else if (cmd_i.step) begin
      if (e_q[0]) begin
        r_d = prod;
      end
      s_d = sq;
      e_d = {1'b0, e_q[7:1]};
    end else if (cmd_i.fin) begin
      r_d = prod;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_q  <= 8'd0;
      nm_q <= 1'b0;
    end else begin
      e_q  <= e_d;
      nm_q <= nm_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q  <= r_d;
    s_q  <= s_d;
    a_q  <= a_d;
    zd_q <= zd_d;
  end

  assign sts_o.exp_zero = (e_q == 8'd0);
  assign sts_o.need_mul = nm_q;
  assign result_o       = r_q;
  assign zero_divisor_o = zd_q;

endmodule

`default_nettype wire

// ===== rtl/gf256_arithmetic_unit.sv =====
// Arithmetic unit over GF(2^8), polynomial 0x11B: multiply, divide, invert
// and signed power. A word is taken when start is high and busy is low; its
// result shows on result_o and zero_divisor_o for exactly one cycle with
// done_o high, and must be captured then since the receiver cannot stall.
// Timing is set by the square-and-multiply loop, one exponent bit per cycle
// over the exponent reduced to 0..254 (254 for divide and invert): after the
// accepting edge the sequencer squares through the exponent bits, passes a
// final multiply state for multiply and divide, then raises done_o; busy falls
// with done_o, so a new word is taken only after the previous result.
// Depends on gf256_pkg, gf256_ctrl, gf256_dp and the assertion macro header.
`default_nettype none
`include "gf256_arithmetic_unit_assert.svh"

module gf256_arithmetic_unit
  import gf256_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [7:0]  operand_a_i,
  input  wire logic [7:0]  operand_b_i,
  input  wire logic [31:0] exponent_i,
  output logic             done_o,
  output logic [7:0]       result_o,
  output logic             zero_divisor_o
);

  gf_cmd_t cmd;
  gf_sts_t sts;

  gf256_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  gf256_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .opcode_i       (opcode_i),
    .operand_a_i    (operand_a_i),
    .operand_b_i    (operand_b_i),
    .exponent_i     (exponent_i),
    .result_o       (result_o),
    .zero_divisor_o (zero_divisor_o)
  );

  `GF_ASSERT_IMP(a_done_busy, done_o, busy)
  `GF_ASSERT_NXT(a_done_pulse, done_o, !done_o && !busy)
  `GF_ASSERT_NXT(a_start_busy, start && !busy, busy && !done_o)
  `GF_ASSERT_IMP(a_cmd_excl, 1'b1, $onehot0({cmd.load, cmd.step, cmd.fin}))

endmodule

`default_nettype wire
